// ----- rtl/tgfc_pkg.sv -----
// Package for the two-generation frame cache: field widths, codes and the result type.
// Used by the engine and the top level; depends on nothing else.
package tgfc_pkg;

    localparam int KEY_WIDTH     = 32;
    localparam int VALUE_WIDTH   = 32;
    localparam int COUNT_WIDTH   = 32;
    localparam int ENTRIES_WIDTH = 7;
    localparam int CAP_WIDTH     = 7;
    localparam int DEPTH_DEFAULT = 64;
    localparam int PADDR_WIDTH   = 3;
    localparam int PDATA_WIDTH   = 32;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;

    // Item kinds carried on the selector.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_SWAP   = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_FRAME_CAPACITY = 1'b0;

    typedef struct packed {
        logic [ENTRIES_WIDTH-1:0] entries;
        logic [COUNT_WIDTH-1:0]   misses;
        logic [COUNT_WIDTH-1:0]   hits;
        logic                     hit;
        logic [VALUE_WIDTH-1:0]   value;
    } result_t;

endpackage

// ----- rtl/tgfc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stands alone; no package needed.
module tgfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tgfc_engine.sv -----
// Lookup engine of the frame cache: scans both banks of the entry RAM, inserts, swaps frames.
// Depends on tgfc_pkg; drives the RAM ports of a tgfc_ram instance in the top level.
module tgfc_engine
    import tgfc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW = $clog2(2 * DEPTH),
    localparam int DW = KEY_WIDTH + VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_func,
    input  logic [KEY_WIDTH-1:0]   in_key,
    input  logic [VALUE_WIDTH-1:0] in_fill,
    input  logic [CAP_WIDTH-1:0]   capacity,
    output logic                   ram_we,
    output logic [AW-1:0]          ram_waddr,
    output logic [DW-1:0]          ram_wdata,
    output logic                   ram_re,
    output logic [AW-1:0]          ram_raddr,
    input  logic [DW-1:0]          ram_rdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output result_t                out_data
);

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic                   bank_reg, bank_next;
    logic [FW-1:0]          fill_reg [2];
    logic [FW-1:0]          fill_next [2];
    logic [SW-1:0]          oldest_reg [2];
    logic [SW-1:0]          oldest_next [2];
    logic [COUNT_WIDTH-1:0] hits_reg, hits_next;
    logic [COUNT_WIDTH-1:0] misses_reg, misses_next;
    logic                   scan_bank_reg, scan_bank_next;
    logic                   pass_reg, pass_next;
    logic [FW-1:0]          issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    // Payload registers, no reset.
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] fill_val_reg, fill_val_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    logic                   res_hit_reg, res_hit_next;

    function automatic logic [SW-1:0] slot_wrap(input logic [SW:0] s);
        logic [SW:0] d;
        d = s - (SW + 1)'(DEPTH);
        if (s >= (SW + 1)'(DEPTH))
        begin
            return d[SW-1:0];
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] bank_addr(input logic b, input logic [SW-1:0] slot);
        logic [AW-1:0] base;
        base = b ? AW'(DEPTH) : '0;
        return base + AW'(slot);
    endfunction

    // Capacity after clamping to the range 1..DEPTH.
    logic [CAP_WIDTH-1:0] cap_nz;
    logic [FW-1:0]        cap_eff;

    always_comb
    begin
        cap_nz = (capacity == '0) ? CAP_WIDTH'(1) : capacity;
        if (32'(cap_nz) > 32'(DEPTH))
        begin
            cap_eff = FW'(DEPTH);
        end
        else
        begin
            cap_eff = FW'(cap_nz);
        end
    end

    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;

    assign rd_key   = ram_rdata[KEY_WIDTH-1:0];
    assign rd_value = ram_rdata[DW-1:KEY_WIDTH];

    always_comb
    begin
        logic          match;
        logic [SW-1:0] ins_oldest;
        logic [FW-1:0] ins_fill;
        logic [SW-1:0] ins_slot;
        logic          drop;

        state_next     = state_reg;
        bank_next      = bank_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        scan_bank_next = scan_bank_reg;
        pass_next      = pass_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        key_next       = key_reg;
        fill_val_next  = fill_val_reg;
        res_value_next = res_value_reg;
        res_hit_next   = res_hit_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = bank_addr(scan_bank_reg,
            slot_wrap((SW + 1)'(oldest_reg[scan_bank_reg]) + (SW + 1)'(issue_reg)));

        match = pend_reg && (rd_key == key_reg);

        drop       = fill_reg[bank_reg] >= cap_eff;
        ins_oldest = drop ? slot_wrap((SW + 1)'(oldest_reg[bank_reg]) + (SW + 1)'(1))
                          : oldest_reg[bank_reg];
        ins_fill   = drop ? fill_reg[bank_reg] - FW'(1) : fill_reg[bank_reg];
        ins_slot   = slot_wrap((SW + 1)'(ins_oldest) + (SW + 1)'(ins_fill));
        ram_waddr  = bank_addr(bank_reg, ins_slot);
        ram_wdata  = {res_value_reg, key_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = in_key;
                    fill_val_next = in_fill;
                    if (in_func == FUNC_SWAP)
                    begin
                        bank_next          = ~bank_reg;
                        fill_next[~bank_reg]   = '0;
                        oldest_next[~bank_reg] = '0;
                        res_value_next     = '0;
                        res_hit_next       = 1'b0;
                        state_next         = ST_FINISH;
                    end
                    else
                    begin
                        scan_bank_next = bank_reg;
                        pass_next      = 1'b0;
                        issue_next     = '0;
                        pend_next      = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // One read is issued per cycle; its data is compared in the next cycle.
                if (match)
                begin
                    res_value_next = rd_value;
                    res_hit_next   = 1'b1;
                    pend_next      = 1'b0;
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + COUNT_WIDTH'(1);
                    end
                    state_next = pass_reg ? ST_INSERT : ST_FINISH;
                end
                else if (issue_reg < fill_reg[scan_bank_reg])
                begin
                    ram_re     = 1'b1;
                    issue_next = issue_reg + FW'(1);
                    pend_next  = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (!pass_reg)
                begin
                    pass_next      = 1'b1;
                    scan_bank_next = ~scan_bank_reg;
                    issue_next     = '0;
                end
                else
                begin
                    res_value_next = fill_val_reg;
                    res_hit_next   = 1'b0;
                    if (misses_reg != '1)
                    begin
                        misses_next = misses_reg + COUNT_WIDTH'(1);
                    end
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                ram_we                = 1'b1;
                oldest_next[bank_reg] = ins_oldest;
                fill_next[bank_reg]   = ins_fill + FW'(1);
                state_next            = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.value   = res_value_reg;
                    out_next.hit     = res_hit_reg;
                    out_next.hits    = hits_reg;
                    out_next.misses  = misses_reg;
                    out_next.entries = ENTRIES_WIDTH'(fill_reg[bank_reg]);
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            oldest_reg[0] <= '0;
            oldest_reg[1] <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            scan_bank_reg <= 1'b0;
            pass_reg      <= 1'b0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            scan_bank_reg <= scan_bank_next;
            pass_reg      <= pass_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        key_reg       <= key_next;
        fill_val_reg  <= fill_val_next;
        res_value_reg <= res_value_next;
        res_hit_reg   <= res_hit_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/two_generation_frame_cache_top.sv -----
// Top level of the two-generation frame cache: stream ports, APB register, entry RAM.
// Depends on tgfc_pkg, tgfc_ram and tgfc_engine.
//
//  Channel   Direction  Handshake                    Carries
//  s_*       in         s_tvalid / s_tready          lookup or end-of-frame request
//  m_*       out        m_tvalid / m_tready          result with totals and fill
//  APB       in/out     psel, penable, pready        frame_capacity at byte address 0
//
// A lookup scans the current frame and then, unless it hits there, the previous frame,
// one entry RAM read per cycle; a hit in the previous frame or a miss then inserts the
// entry into the current frame. An end-of-frame request swaps the frames and empties
// the new current one. Reset leaves both frames empty; the RAM needs no clearing. The
// next request is taken while a result waits at m_*; the engine holds its result until
// the output register is free.
module two_generation_frame_cache_top
    import tgfc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // lookup_key[31:0], fill_value[63:32]
    input  logic                   s_tuser,   // func[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [103:0]           m_tdata,   // result_value[31:0], hit_total[63:32],
                                              // miss_total[95:64], current_entries[102:96]
    output logic                   m_tuser,   // was_hit[0]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready
);

    localparam int AW = $clog2(2 * DEPTH);
    localparam int DW = KEY_WIDTH + VALUE_WIDTH;

    logic [CAP_WIDTH-1:0] capacity_reg, capacity_next;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [DW-1:0]        ram_wdata, ram_rdata;
    result_t              result;

    assign pready = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        prdata        = '0;
        unique case (paddr[2])
            REG_FRAME_CAPACITY:
            begin
                prdata = PDATA_WIDTH'(capacity_reg);
                if (psel && penable && pwrite && pready)
                begin
                    capacity_next = pwdata[CAP_WIDTH-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    tgfc_ram #(
        .WIDTH(DW),
        .DEPTH(2 * DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tgfc_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tuser),
        .in_key   (s_tdata[KEY_WIDTH-1:0]),
        .in_fill  (s_tdata[DW-1:KEY_WIDTH]),
        .capacity (capacity_reg),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (result)
    );

    assign m_tdata = {1'b0, result.entries, result.misses, result.hits, result.value};
    assign m_tuser = result.hit;

endmodule
